@@ rtl/mcodp_pkg.sv @@
// ----------------------------------------------------------------------------
// mcodp_pkg
// Shared constants and controller/datapath interface types for the
// matrix chain order block.
// ----------------------------------------------------------------------------
package mcodp_pkg;

    localparam int MAX_MATRICES_DEF = 8;
    localparam int DIM_BITS_DEF     = 12;

    // fixed result field widths
    localparam int IDX_W      = 4;
    localparam int SPLIT_W    = 4;
    localparam int COST_W     = 40;
    localparam int OUT_DATA_W = 56;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // controller to datapath
    typedef struct packed {
        logic             valid;     // split candidate issued this cycle
        logic             first;     // k equals i
        logic             last;      // k equals j-1
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] k;
        logic [IDX_W-1:0] j;
        logic             dim_we;
        logic [IDX_W-1:0] dim_waddr;
        logic             out_load;
        logic             out_zero;  // cost and split forced to zero
        logic             out_err;
        logic             out_last;
        logic [IDX_W-1:0] out_row;
        logic [IDX_W-1:0] out_col;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic busy;      // candidates still in the pipeline
        logic out_free;  // output register can take an item
    } t_dp_stat;

endpackage

@@ rtl/mcodp_ram.sv @@
// ----------------------------------------------------------------------------
// mcodp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcodp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/mcodp_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcodp_ctrl
// Sequencer: loads dimensions, walks diagonals/pairs/splits for the
// table fill, then walks the pairs in row order to emit results.
// ----------------------------------------------------------------------------
module mcodp_ctrl #(
    parameter int MAX_MATRICES = mcodp_pkg::MAX_MATRICES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tlast,
    output logic                o_s_tready,
    input  mcodp_pkg::t_dp_stat i_stat,
    output mcodp_pkg::t_dp_cmd  o_cmd
);

    localparam int IW          = mcodp_pkg::IDX_W;
    localparam int STORE_DEPTH = MAX_MATRICES + 1;
    localparam int COUNT_SAT   = MAX_MATRICES + 2;
    localparam int CW          = $clog2(COUNT_SAT + 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_COMP     = 7'b0000010,
        S_DRAIN    = 7'b0000100,
        S_OUT_RD   = 7'b0001000,
        S_OUT_LD   = 7'b0010000,
        S_EMIT_ERR = 7'b0100000,
        S_EMIT_ONE = 7'b1000000
    } t_state;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [IW-1:0]  r_n, n_n;
    logic [IW-1:0]  r_d, n_d;
    logic [IW-1:0]  r_i, n_i;
    logic [IW-1:0]  r_j, n_j;
    logic [IW-1:0]  r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_n <= n_n;
        r_d <= n_d;
        r_i <= n_i;
        r_j <= n_j;
        r_k <= n_k;
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_n     = r_n;
        n_d     = r_d;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        o_cmd   = '0;
        o_cmd.i = r_i;
        o_cmd.j = r_j;
        o_cmd.k = r_k;
        o_cmd.dim_waddr = IW'(r_count);

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.dim_we = (r_count < CW'(STORE_DEPTH));
                    if (!i_s_tlast) begin
                        if (r_count < CW'(COUNT_SAT)) begin
                            n_count = r_count + CW'(1);
                        end
                    end else begin
                        n_count = '0;
                        if (r_count == '0 || r_count >= CW'(STORE_DEPTH)) begin
                            n_state = S_EMIT_ERR;
                        end else if (r_count == CW'(1)) begin
                            n_state = S_EMIT_ONE;
                        end else begin
                            n_n     = IW'(r_count);
                            n_d     = IW'(1);
                            n_i     = IW'(1);
                            n_j     = IW'(2);
                            n_k     = IW'(1);
                            n_state = S_COMP;
                        end
                    end
                end
            end

            // one split candidate per cycle; pairs of one diagonal run back to back
            S_COMP: begin
                o_cmd.valid = 1'b1;
                o_cmd.first = (r_k == r_i);
                o_cmd.last  = (r_k == r_j - IW'(1));
                if (r_k == r_j - IW'(1)) begin
                    if (r_j == r_n) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_i = r_i + IW'(1);
                        n_j = r_j + IW'(1);
                        n_k = r_i + IW'(1);
                    end
                end else begin
                    n_k = r_k + IW'(1);
                end
            end

            // next diagonal reads what this one writes
            S_DRAIN: begin
                if (!i_stat.busy) begin
                    if (r_d == r_n - IW'(1)) begin
                        n_i     = IW'(1);
                        n_j     = IW'(2);
                        n_state = S_OUT_RD;
                    end else begin
                        n_d     = r_d + IW'(1);
                        n_i     = IW'(1);
                        n_j     = r_d + IW'(2);
                        n_k     = IW'(1);
                        n_state = S_COMP;
                    end
                end
            end

            S_OUT_RD: begin
                o_cmd.k = r_j;
                n_state = S_OUT_LD;
            end

            S_OUT_LD: begin
                o_cmd.k       = r_j;
                o_cmd.out_row = r_i;
                o_cmd.out_col = r_j;
                o_cmd.out_last = (r_i == r_n - IW'(1)) && (r_j == r_n);
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_j == r_n) begin
                        if (r_i == r_n - IW'(1)) begin
                            n_state = S_IDLE;
                        end else begin
                            n_i     = r_i + IW'(1);
                            n_j     = r_i + IW'(2);
                            n_state = S_OUT_RD;
                        end
                    end else begin
                        n_j     = r_j + IW'(1);
                        n_state = S_OUT_RD;
                    end
                end
            end

            S_EMIT_ERR: begin
                o_cmd.out_zero = 1'b1;
                o_cmd.out_err  = 1'b1;
                o_cmd.out_last = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            S_EMIT_ONE: begin
                o_cmd.out_zero = 1'b1;
                o_cmd.out_last = 1'b1;
                o_cmd.out_row  = IW'(1);
                o_cmd.out_col  = IW'(1);
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/mcodp_dp.sv @@
// ----------------------------------------------------------------------------
// mcodp_dp
// Datapath: dimension and cost stores, four-stage candidate pipeline
// with running minimum, and the output register.
// ----------------------------------------------------------------------------
module mcodp_dp #(
    parameter int MAX_MATRICES = mcodp_pkg::MAX_MATRICES_DEF,
    parameter int DIM_BITS     = mcodp_pkg::DIM_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mcodp_pkg::t_dp_cmd                  i_cmd,
    input  logic [DIM_BITS-1:0]                 i_dimension,
    output mcodp_pkg::t_dp_stat                 o_stat,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [mcodp_pkg::IDX_W-1:0]         o_row,
    output logic [mcodp_pkg::IDX_W-1:0]         o_col,
    output logic [mcodp_pkg::COST_W-1:0]        o_cost,
    output logic [mcodp_pkg::SPLIT_W-1:0]       o_split,
    output logic                                o_error,
    output logic                                o_end_of_run
);

    localparam int IW     = mcodp_pkg::IDX_W;
    localparam int CSTW   = mcodp_pkg::COST_W;
    localparam int DDEPTH = MAX_MATRICES + 1;
    localparam int DAW    = $clog2(DDEPTH);
    localparam int TDEPTH = MAX_MATRICES * MAX_MATRICES;
    localparam int TW     = $clog2(TDEPTH);
    localparam int EW     = CSTW + IW;
    localparam int PW     = 3 * DIM_BITS;
    localparam int XW     = (PW > CSTW) ? PW : CSTW;

    function automatic logic [TW-1:0] tix(input logic [IW-1:0] a, input logic [IW-1:0] b);
        tix = TW'((int'(a) - 1) * MAX_MATRICES + int'(b) - 1);
    endfunction

    // ---- stores ----
    logic [EW-1:0]       w_ca, w_cb;
    logic [DIM_BITS-1:0] w_da, w_db, w_dc;
    logic                w_we;
    logic [TW-1:0]       w_waddr;
    logic [EW-1:0]       w_wdata;

    mcodp_ram #(.WIDTH(EW), .DEPTH(TDEPTH)) u_cost_a (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(tix(i_cmd.i, i_cmd.k)), .o_rdata(w_ca)
    );

    mcodp_ram #(.WIDTH(EW), .DEPTH(TDEPTH)) u_cost_b (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(tix(i_cmd.k + IW'(1), i_cmd.j)), .o_rdata(w_cb)
    );

    mcodp_ram #(.WIDTH(DIM_BITS), .DEPTH(DDEPTH)) u_dim_a (
        .i_clk(i_clk), .i_we(i_cmd.dim_we), .i_waddr(i_cmd.dim_waddr[DAW-1:0]),
        .i_wdata(i_dimension), .i_raddr(DAW'(i_cmd.i - IW'(1))), .o_rdata(w_da)
    );

    mcodp_ram #(.WIDTH(DIM_BITS), .DEPTH(DDEPTH)) u_dim_b (
        .i_clk(i_clk), .i_we(i_cmd.dim_we), .i_waddr(i_cmd.dim_waddr[DAW-1:0]),
        .i_wdata(i_dimension), .i_raddr(i_cmd.k[DAW-1:0]), .o_rdata(w_db)
    );

    mcodp_ram #(.WIDTH(DIM_BITS), .DEPTH(DDEPTH)) u_dim_c (
        .i_clk(i_clk), .i_we(i_cmd.dim_we), .i_waddr(i_cmd.dim_waddr[DAW-1:0]),
        .i_wdata(i_dimension), .i_raddr(i_cmd.j[DAW-1:0]), .o_rdata(w_dc)
    );

    // ---- candidate pipeline ----
    logic                  r_v1, r_v2, r_v3, r_v4;
    logic                  r_f1, r_f2, r_f3, r_f4;
    logic                  r_l1, r_l2, r_l3, r_l4;
    logic [IW-1:0]         r_k1, r_k2, r_k3, r_k4;
    logic [TW-1:0]         r_wa1, r_wa2, r_wa3, r_wa4;
    logic [CSTW-1:0]       r_sum2, r_sum3;
    logic [2*DIM_BITS-1:0] r_prod2;
    logic [DIM_BITS-1:0]   r_dc2;
    logic [PW-1:0]         r_prod3;
    logic [CSTW-1:0]       r_val4;
    logic [CSTW-1:0]       r_best;
    logic [IW-1:0]         r_bk;

    logic [CSTW-1:0] w_left, w_right, w_prod_sat, w_best;
    logic [CSTW:0]   w_sum1, w_sum3;
    logic [XW-1:0]   w_px;
    logic [IW-1:0]   w_bk;
    logic            w_take;

    always_comb begin
        // diagonal entries are zero and never stored
        w_left     = r_f1 ? '0 : w_ca[CSTW-1:0];
        w_right    = r_l1 ? '0 : w_cb[CSTW-1:0];
        w_sum1     = {1'b0, w_left} + {1'b0, w_right};
        w_px       = XW'(r_prod3);
        w_prod_sat = (w_px > XW'(mcodp_pkg::COST_MAX)) ? mcodp_pkg::COST_MAX : w_px[CSTW-1:0];
        w_sum3     = {1'b0, r_sum3} + {1'b0, w_prod_sat};
        // strict compare keeps the first minimum
        w_take     = r_f4 || (r_val4 < r_best);
        w_best     = w_take ? r_val4 : r_best;
        w_bk       = w_take ? r_k4 : r_bk;
        w_we       = r_v4 && r_l4;
        w_waddr    = r_wa4;
        w_wdata    = {w_bk, w_best};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        r_f1  <= i_cmd.first;
        r_l1  <= i_cmd.last;
        r_k1  <= i_cmd.k;
        r_wa1 <= tix(i_cmd.i, i_cmd.j);

        r_f2    <= r_f1;
        r_l2    <= r_l1;
        r_k2    <= r_k1;
        r_wa2   <= r_wa1;
        r_sum2  <= w_sum1[CSTW] ? mcodp_pkg::COST_MAX : w_sum1[CSTW-1:0];
        r_prod2 <= w_da * w_db;
        r_dc2   <= w_dc;

        r_f3    <= r_f2;
        r_l3    <= r_l2;
        r_k3    <= r_k2;
        r_wa3   <= r_wa2;
        r_sum3  <= r_sum2;
        r_prod3 <= r_prod2 * r_dc2;

        r_f4   <= r_f3;
        r_l4   <= r_l3;
        r_k4   <= r_k3;
        r_wa4  <= r_wa3;
        r_val4 <= w_sum3[CSTW] ? mcodp_pkg::COST_MAX : w_sum3[CSTW-1:0];

        if (r_v4) begin
            r_best <= w_best;
            r_bk   <= w_bk;
        end
    end

    // ---- output register ----
    logic                          r_m_valid;
    logic [IW-1:0]                 r_row, r_col;
    logic [CSTW-1:0]               r_cost;
    logic [mcodp_pkg::SPLIT_W-1:0] r_split;
    logic                          r_err, r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_row   <= i_cmd.out_row;
            r_col   <= i_cmd.out_col;
            r_cost  <= i_cmd.out_zero ? '0 : w_ca[CSTW-1:0];
            r_split <= i_cmd.out_zero ? '0 : mcodp_pkg::SPLIT_W'(w_ca[CSTW +: IW]);
            r_err   <= i_cmd.out_err;
            r_last  <= i_cmd.out_last;
        end
    end

    assign o_stat.busy     = r_v1 | r_v2 | r_v3 | r_v4;
    assign o_stat.out_free = !r_m_valid || i_m_tready;
    assign o_m_tvalid      = r_m_valid;
    assign o_row           = r_row;
    assign o_col           = r_col;
    assign o_cost          = r_cost;
    assign o_split         = r_split;
    assign o_error         = r_err;
    assign o_end_of_run    = r_last;

endmodule

@@ rtl/matrix_chain_order_dp.sv @@
// Loading: one dimension item per cycle, accepted while no chain is being solved or emitted.
// Solve after the closing item: one split candidate per cycle through a four-stage
// multiply/add/compare pipeline that drains between diagonals. Results are then read
// out pair by pair through S_OUT_RD and S_OUT_LD, waiting while the output is stalled.
// Error and single-matrix chains give their one result via S_EMIT_ERR or S_EMIT_ONE.
// Reset (i_rst_n low, synchronous) clears the count, FSM and valids; stores need no clear.
// ----------------------------------------------------------------------------
// matrix_chain_order_dp
// Least-cost matrix chain ordering by interval dynamic programming; emits
// cost and best split for every sub-chain i<j in row order.
// ----------------------------------------------------------------------------
module matrix_chain_order_dp #(
    parameter int MAX_MATRICES = mcodp_pkg::MAX_MATRICES_DEF,
    parameter int DIM_BITS     = mcodp_pkg::DIM_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((DIM_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // dimension
    input  logic                                s_axis_tlast,  // final_dim
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mcodp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // row, col, cost, split
    output logic [0:0]                          m_axis_tuser,  // error
    output logic                                m_axis_tlast   // end_of_run
);

    mcodp_pkg::t_dp_cmd  w_cmd;
    mcodp_pkg::t_dp_stat w_stat;

    logic [mcodp_pkg::IDX_W-1:0]   w_row, w_col;
    logic [mcodp_pkg::COST_W-1:0]  w_cost;
    logic [mcodp_pkg::SPLIT_W-1:0] w_split;
    logic                          w_error;

    mcodp_ctrl #(.MAX_MATRICES(MAX_MATRICES)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tlast  (s_axis_tlast),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mcodp_dp #(.MAX_MATRICES(MAX_MATRICES), .DIM_BITS(DIM_BITS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_dimension  (s_axis_tdata[DIM_BITS-1:0]),
        .o_stat       (w_stat),
        .i_m_tready   (m_axis_tready),
        .o_m_tvalid   (m_axis_tvalid),
        .o_row        (w_row),
        .o_col        (w_col),
        .o_cost       (w_cost),
        .o_split      (w_split),
        .o_error      (w_error),
        .o_end_of_run (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, w_split, w_cost, w_col, w_row};
    assign m_axis_tuser = w_error;

endmodule
